@@ hdl/fsge_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsge_pkg - shared types and constants of the falling-sand grid engine
// Sequencer states, register indexes, reset values and chunk geometry of the
// column-serial gravity unit.
// ----------------------------------------------------------------------------
package fsge_pkg;

  // columns settled per cycle by the gravity unit
  localparam int CHUNK_COLS = 8;
  // window into the row below: one column on each side of the chunk
  localparam int WIN_W      = CHUNK_COLS + 2;

  localparam logic [7:0] SPAWN_RESET = 8'd64;
  localparam logic [7:0] WAIT_RESET  = 8'd16;

  // register index, taken from paddr[2]
  localparam logic REG_SPAWN = 1'b0;
  localparam logic REG_WAIT  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLR,     // clear the grid after reset
    ST_IDLE,    // wait for a frame tick
    ST_E_RD,    // read the next row for output
    ST_E_LD,    // load the output register
    ST_G_RD0,   // gravity: read row 0
    ST_G_LD0,   // gravity: capture row 0, read row 1
    ST_G_LD,    // gravity: capture the row below
    ST_G_RUN,   // gravity: settle one chunk of columns
    ST_G_WB,    // gravity: write back the finished row
    ST_G_LAST,  // gravity: write back the bottom row
    ST_S_RD,    // shift: read row 0
    ST_S_RUN    // shift: move each row down one
  } state_t;

endpackage

@@ hdl/fsge_chunk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsge_chunk - gravity settle for one chunk of columns
// Walks the chunk's grains from low column to high and drops each into the
// row below: straight down, else down-left, else down-right. Occupied bits
// at the window edges stand for missing columns.
// ----------------------------------------------------------------------------
module fsge_chunk (
  input  logic [fsge_pkg::CHUNK_COLS-1:0] grains_i,
  input  logic [fsge_pkg::WIN_W-1:0]      below_i,
  output logic [fsge_pkg::WIN_W-1:0]      below_o,
  output logic [fsge_pkg::CHUNK_COLS-1:0] moved_o
);

  logic [fsge_pkg::WIN_W-1:0]      win_w;
  logic [fsge_pkg::CHUNK_COLS-1:0] mv_w;

  // window bit i+1 is the column of grain i
  always_comb begin
    win_w = below_i;
    mv_w  = '0;
    for (int i = 0; i < fsge_pkg::CHUNK_COLS; i++) begin
      if (grains_i[i]) begin
        if (!win_w[i+1]) begin
          win_w[i+1] = 1'b1;
          mv_w[i]    = 1'b1;
        end else if (!win_w[i]) begin
          win_w[i]   = 1'b1;
          mv_w[i]    = 1'b1;
        end else if (!win_w[i+2]) begin
          win_w[i+2] = 1'b1;
          mv_w[i]    = 1'b1;
        end
      end
    end
  end

  assign below_o = win_w;
  assign moved_o = mv_w;

endmodule

@@ hdl/falling_sand_grid_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falling_sand_grid_engine_core - falling-sand grid engine
// One frame tick per input item; each active frame emits every grid row and
// then applies a gravity pass or a one-row clearing shift to the grid memory.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     in_spawn_row
//   out_     output     out_valid / out_ready   out_row_index, out_row_bits,
//                                               out_last_row, out_clearing_phase
//   cfg      APB        psel/penable/pready     paddr, pwdata, prdata
//
// Sequence: a waiting tick leaves the sequencer idle. An active frame emits
// the rows (one grid memory read each), then runs either a gravity pass,
// settled by the 8-column settle unit one chunk at a time, or a shift pass.
// Reset: a sweep over every row clears the grid memory; no item is taken then.
// Stalls: out_ready low holds the row sweep; the last row may wait in the
// output register while the step runs and the next tick is taken.
// ----------------------------------------------------------------------------
module falling_sand_grid_engine_core #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // frame ticks
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_spawn_row,
  // grid rows
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_row_index,
  output logic [63:0] out_row_bits,
  output logic        out_last_row,
  output logic        out_clearing_phase,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CHUNKS = (COLUMNS + fsge_pkg::CHUNK_COLS - 1) / fsge_pkg::CHUNK_COLS;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int LCC    = $clog2(fsge_pkg::CHUNK_COLS);
  localparam int SW     = CW + LCC;
  localparam int PW     = CHUNKS * fsge_pkg::CHUNK_COLS + 2;
  localparam int PADW   = PW - COLUMNS - 1;

  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [RW-1:0] PENULT_ROW = RW'(ROWS - 2);
  localparam logic [CW-1:0] LAST_CHUNK = CW'(CHUNKS - 1);

  fsge_pkg::state_t state_r, state_nxt;

  logic [RW-1:0]      y_r;
  logic [CW-1:0]      chunk_r;
  logic [7:0]         spawn_left_r;
  logic [7:0]         wait_left_r;
  logic               clearing_r;
  logic               moved_r;
  logic               hit_r;
  logic [7:0]         spawn_cfg_r;
  logic [7:0]         wait_cfg_r;
  logic               out_valid_r;

  logic [COLUMNS-1:0] old_r;        // old grid row y
  logic [COLUMNS-1:0] cur_r;        // working row y (shift: row carried down)
  logic [COLUMNS-1:0] old_below_r;  // old grid row y+1
  logic [COLUMNS-1:0] below_r;      // working row y+1
  logic [COLUMNS-1:0] rd_data_r;
  logic [5:0]         out_row_index_r;
  logic [63:0]        out_row_bits_r;
  logic               out_last_row_r;
  logic               out_clearing_r;

  logic               mem_we;
  logic [RW-1:0]      mem_waddr;
  logic [COLUMNS-1:0] mem_wdata;
  logic               mem_re;
  logic [RW-1:0]      mem_raddr;
  logic [COLUMNS-1:0] grid_mem [ROWS];

  logic               in_acc;
  logic               out_free;
  logic               cfg_wr;

  logic [SW-1:0]                     sh;
  logic [PW-1:0]                     below_ext;
  logic [PW-1:0]                     old_ext;
  logic [PW-1:0]                     below_sh;
  logic [PW-1:0]                     old_sh;
  logic [PW-1:0]                     below_upd_ext;
  logic [PW-1:0]                     clr_ext;
  logic [COLUMNS-1:0]                below_upd;
  logic [COLUMNS-1:0]                cur_upd;
  logic [fsge_pkg::WIN_W-1:0]        win_in;
  logic [fsge_pkg::WIN_W-1:0]        win_out;
  logic [fsge_pkg::CHUNK_COLS-1:0]   grains;
  logic [fsge_pkg::CHUNK_COLS-1:0]   mv;

  assign in_ready = (state_r == fsge_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  always_comb begin
    case (paddr[2])
      fsge_pkg::REG_SPAWN: prdata = {24'd0, spawn_cfg_r};
      fsge_pkg::REG_WAIT:  prdata = {24'd0, wait_cfg_r};
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // grid memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= grid_mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // gravity chunk datapath; missing columns read as occupied below
  // --------------------------------------------------------------------------
  always_comb begin
    sh            = {chunk_r, {LCC{1'b0}}};
    below_ext     = {{PADW{1'b1}}, below_r, 1'b1};
    old_ext       = {{PADW{1'b0}}, old_r, 1'b0};
    below_sh      = below_ext >> sh;
    old_sh        = old_ext >> sh;
    win_in        = below_sh[fsge_pkg::WIN_W-1:0];
    grains        = old_sh[fsge_pkg::CHUNK_COLS:1];
    below_upd_ext = (below_ext & ~(PW'({fsge_pkg::WIN_W{1'b1}}) << sh))
                  | (PW'(win_out) << sh);
    clr_ext       = PW'({mv, 1'b0}) << sh;
    below_upd     = below_upd_ext[COLUMNS:1];
    cur_upd       = cur_r & ~clr_ext[COLUMNS:1];
  end

  fsge_chunk u_chunk (
    .grains_i (grains),
    .below_i  (win_in),
    .below_o  (win_out),
    .moved_o  (mv)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsge_pkg::ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = y_r;
    mem_wdata = cur_r;
    mem_re    = 1'b0;
    mem_raddr = y_r;
    case (state_r)
      fsge_pkg::ST_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (y_r == LAST_ROW) begin
          state_nxt = fsge_pkg::ST_IDLE;
        end
      end
      fsge_pkg::ST_IDLE: begin
        if (in_acc && wait_left_r == 8'd0) begin
          if (spawn_left_r != 8'd0) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = in_spawn_row[COLUMNS-1:0];
          end
          state_nxt = fsge_pkg::ST_E_RD;
        end
      end
      fsge_pkg::ST_E_RD: begin
        // read only when the output register is free by the next edge
        if (out_free) begin
          mem_re    = 1'b1;
          state_nxt = fsge_pkg::ST_E_LD;
        end
      end
      fsge_pkg::ST_E_LD: begin
        if (y_r == LAST_ROW) begin
          state_nxt = clearing_r ? fsge_pkg::ST_S_RD : fsge_pkg::ST_G_RD0;
        end else begin
          state_nxt = fsge_pkg::ST_E_RD;
        end
      end
      fsge_pkg::ST_G_RD0: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = fsge_pkg::ST_G_LD0;
      end
      fsge_pkg::ST_G_LD0: begin
        mem_re    = 1'b1;
        mem_raddr = RW'(1);
        state_nxt = fsge_pkg::ST_G_LD;
      end
      fsge_pkg::ST_G_LD: begin
        state_nxt = fsge_pkg::ST_G_RUN;
      end
      fsge_pkg::ST_G_RUN: begin
        if (chunk_r == LAST_CHUNK) begin
          state_nxt = fsge_pkg::ST_G_WB;
        end
      end
      fsge_pkg::ST_G_WB: begin
        mem_we = 1'b1;
        if (y_r == PENULT_ROW) begin
          state_nxt = fsge_pkg::ST_G_LAST;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = y_r + RW'(2);
          state_nxt = fsge_pkg::ST_G_LD;
        end
      end
      fsge_pkg::ST_G_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = LAST_ROW;
        state_nxt = fsge_pkg::ST_IDLE;
      end
      fsge_pkg::ST_S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = fsge_pkg::ST_S_RUN;
      end
      fsge_pkg::ST_S_RUN: begin
        mem_we = 1'b1;
        if (y_r == LAST_ROW) begin
          state_nxt = fsge_pkg::ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = y_r + RW'(1);
        end
      end
      default: begin
        state_nxt = fsge_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r          <= '0;
      chunk_r      <= '0;
      spawn_left_r <= fsge_pkg::SPAWN_RESET;
      wait_left_r  <= 8'd0;
      clearing_r   <= 1'b0;
      moved_r      <= 1'b0;
      hit_r        <= 1'b0;
      spawn_cfg_r  <= fsge_pkg::SPAWN_RESET;
      wait_cfg_r   <= fsge_pkg::WAIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != fsge_pkg::ST_E_LD) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[2])
          fsge_pkg::REG_SPAWN: spawn_cfg_r <= pwdata[7:0];
          fsge_pkg::REG_WAIT:  wait_cfg_r  <= pwdata[7:0];
          default: ;
        endcase
      end
      case (state_r)
        fsge_pkg::ST_CLR: begin
          y_r <= (y_r == LAST_ROW) ? '0 : y_r + RW'(1);
        end
        fsge_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (wait_left_r != 8'd0) begin
              wait_left_r <= wait_left_r - 8'd1;
            end else begin
              if (spawn_left_r != 8'd0) begin
                spawn_left_r <= spawn_left_r - 8'd1;
              end
              y_r <= '0;
            end
          end
        end
        fsge_pkg::ST_E_LD: begin
          out_valid_r <= 1'b1;
          moved_r     <= 1'b0;
          hit_r       <= 1'b0;
          y_r         <= (y_r == LAST_ROW) ? '0 : y_r + RW'(1);
        end
        fsge_pkg::ST_G_LD: begin
          chunk_r <= '0;
        end
        fsge_pkg::ST_G_RUN: begin
          if (mv != '0) begin
            moved_r <= 1'b1;
          end
          chunk_r <= chunk_r + CW'(1);
        end
        fsge_pkg::ST_G_WB: begin
          y_r <= y_r + RW'(1);
        end
        fsge_pkg::ST_G_LAST: begin
          // nothing fell: settle, then wait before clearing
          if (!moved_r) begin
            clearing_r  <= 1'b1;
            wait_left_r <= wait_cfg_r;
          end
          y_r <= '0;
        end
        fsge_pkg::ST_S_RUN: begin
          if (y_r != LAST_ROW) begin
            if (rd_data_r != '0) begin
              hit_r <= 1'b1;
            end
            y_r <= y_r + RW'(1);
          end else begin
            if (!hit_r) begin
              clearing_r   <= 1'b0;
              spawn_left_r <= spawn_cfg_r;
            end
            y_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // row and output data registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      fsge_pkg::ST_E_LD: begin
        out_row_index_r <= 6'(y_r);
        out_row_bits_r  <= 64'(rd_data_r);
        out_last_row_r  <= (y_r == LAST_ROW);
        out_clearing_r  <= clearing_r;
      end
      fsge_pkg::ST_G_LD0: begin
        old_r <= rd_data_r;
        cur_r <= rd_data_r;
      end
      fsge_pkg::ST_G_LD: begin
        old_below_r <= rd_data_r;
        below_r     <= rd_data_r;
      end
      fsge_pkg::ST_G_RUN: begin
        below_r <= below_upd;
        cur_r   <= cur_upd;
      end
      fsge_pkg::ST_G_WB: begin
        // advance one row: the row below becomes the current row
        old_r <= old_below_r;
        cur_r <= below_r;
      end
      fsge_pkg::ST_S_RD: begin
        cur_r <= '0;
      end
      fsge_pkg::ST_S_RUN: begin
        cur_r <= rd_data_r;
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_row_index      = out_row_index_r;
  assign out_row_bits       = out_row_bits_r;
  assign out_last_row       = out_last_row_r;
  assign out_clearing_phase = out_clearing_r;

`ifndef SYNTH
  a_mem_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("grid memory read and write hit the same row");

  a_last_row_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_row) |-> (out_row_index == 6'(ROWS - 1)))
    else $error("last row flag on a row other than the bottom one");

  a_wait_in_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_left_r != 8'd0) |-> clearing_r)
    else $error("wait frames pending outside the clearing phase");
`endif

endmodule

@@ sim/tb_falling_sand_grid_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_falling_sand_grid_engine_core - self-checking bench of the sand engine
// Sends frame ticks and collects the emitted grid rows. A behavioral copy of
// the grid, the spawn and wait counters and the phase flag predicts every
// row. Each received row is checked field by field against the oldest
// prediction. A short table of ticks runs first, then random ticks in
// phases, with the counts rewritten over APB between phases.
// ----------------------------------------------------------------------------
module tb_falling_sand_grid_engine_core;

  localparam int          COLUMNS       = 64;
  localparam int          ROWS          = 64;
  localparam logic [63:0] COL_MASK      = {64{1'b1}} >> (64 - COLUMNS);
  localparam int          SETTLE_CYCLES = 1000;
  localparam int          MAX_REPORTS   = 40;
  localparam logic [2:0]  ADDR_SPAWN    = {fsge_pkg::REG_SPAWN, 2'b00};
  localparam logic [2:0]  ADDR_WAIT     = {fsge_pkg::REG_WAIT, 2'b00};
  localparam int          NUM_TABLE     = 20;
  localparam int          NUM_PHASES    = 5;

  typedef struct packed {
    logic [5:0]  row_index;
    logic [63:0] row_bits;
    logic        last_row;
    logic        clearing_phase;
  } grid_row_t;

  typedef struct packed {
    logic [63:0] spawn_row;
    logic        top_known;
    logic [63:0] top_row;
  } tick_vec_t;

  typedef struct packed {
    logic [7:0] spawn_count;
    logic [7:0] wait_count;
    logic [15:0] frames;
  } phase_t;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [63:0] in_spawn_row  = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [5:0]  out_row_index;
  logic [63:0] out_row_bits;
  logic        out_last_row;
  logic        out_clearing_phase;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // predicted engine state
  logic [63:0] grain_q [ROWS];
  logic [7:0]  spawn_left_q;
  logic [7:0]  wait_left_q;
  logic        clearing_q;
  logic [7:0]  spawn_cfg_q;
  logic [7:0]  wait_cfg_q;

  grid_row_t   expected_rows [$];
  grid_row_t   row_head;
  int          errors        = 0;
  int          stall_left    = 0;
  bit          quiet         = 1'b0;

  // extremes of the spawn row; top row of a spawning frame is the spawn row
  tick_vec_t directed_ticks [NUM_TABLE] = '{
    '{64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{64'h0000_0000_0000_0001, 1'b1, 64'h0000_0000_0000_0001},
    '{64'h8000_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0000},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA},
    '{64'h5555_5555_5555_5555, 1'b1, 64'h5555_5555_5555_5555},
    '{64'h8000_0000_0000_0001, 1'b1, 64'h8000_0000_0000_0001},
    '{64'h0000_0000_FFFF_FFFF, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_0000_0000, 1'b0, 64'h0},
    '{64'h0123_4567_89AB_CDEF, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{64'h0000_0001_8000_0000, 1'b0, 64'h0},
    '{64'hF0F0_F0F0_F0F0_F0F0, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0003, 1'b0, 64'h0},
    '{64'hC000_0000_0000_0000, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0000, 1'b0, 64'h0}
  };

  // count settings per phase, extremes included; frames are active frames
  phase_t sand_phases [NUM_PHASES] = '{
    '{8'd2,   8'd0,   16'd110},
    '{8'd0,   8'd3,   16'd30},
    '{8'd255, 8'd8,   16'd20},
    '{8'd1,   8'd1,   16'd60},
    '{8'd4,   8'd0,   16'd40}
  };

  falling_sand_grid_engine_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_spawn_row      (in_spawn_row),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_row_index     (out_row_index),
    .out_row_bits      (out_row_bits),
    .out_last_row      (out_last_row),
    .out_clearing_phase(out_clearing_phase),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void reset_grid_model();
    for (int y = 0; y < ROWS; y++) grain_q[y] = '0;
    spawn_cfg_q  = fsge_pkg::SPAWN_RESET;
    wait_cfg_q   = fsge_pkg::WAIT_RESET;
    spawn_left_q = fsge_pkg::SPAWN_RESET;
    wait_left_q  = '0;
    clearing_q   = 1'b0;
  endfunction

  // one gravity pass: scan the old grid, settle into a working copy
  function automatic bit settle_grains();
    logic [63:0] work [ROWS];
    bit          moved;
    int          dest;
    moved = 1'b0;
    for (int y = 0; y < ROWS; y++) work[y] = grain_q[y];
    for (int y = 0; y + 1 < ROWS; y++) begin
      for (int x = 0; x < COLUMNS; x++) begin
        dest = -1;
        if (grain_q[y][x]) begin
          if (!work[y+1][x]) begin
            dest = x;
          end else if (x > 0) begin
            if (!work[y+1][x-1]) dest = x - 1;
          end
          if (dest < 0 && x + 1 < COLUMNS) begin
            if (!work[y+1][x+1]) dest = x + 1;
          end
        end
        if (dest >= 0) begin
          work[y][x]       = 1'b0;
          work[y+1][dest]  = 1'b1;
          moved            = 1'b1;
        end
      end
    end
    for (int y = 0; y < ROWS; y++) grain_q[y] = work[y];
    return moved;
  endfunction

  // move every row down one; report whether the moved rows held a grain
  function automatic bit shift_grid_down();
    bit any;
    any = 1'b0;
    for (int y = ROWS - 1; y > 0; y--) begin
      grain_q[y] = grain_q[y-1];
      if (grain_q[y] != '0) any = 1'b1;
    end
    grain_q[0] = '0;
    return any;
  endfunction

  // advance the grid by one tick; queue the rows it emits
  function automatic bit advance_frame(input logic [63:0] spawn_row);
    grid_row_t r;
    if (wait_left_q != 0) begin
      wait_left_q = wait_left_q - 8'd1;
      return 1'b0;
    end
    if (spawn_left_q != 0) begin
      grain_q[0]   = spawn_row & COL_MASK;
      spawn_left_q = spawn_left_q - 8'd1;
    end
    for (int y = 0; y < ROWS; y++) begin
      r.row_index      = 6'(y);
      r.row_bits       = grain_q[y] & COL_MASK;
      r.last_row       = (y == ROWS - 1);
      r.clearing_phase = clearing_q;
      expected_rows.push_back(r);
    end
    if (clearing_q) begin
      if (!shift_grid_down()) begin
        clearing_q   = 1'b0;
        spawn_left_q = spawn_cfg_q;
      end
    end else if (!settle_grains()) begin
      clearing_q  = 1'b1;
      wait_left_q = wait_cfg_q;
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] random_spawn_row();
    logic [63:0] a;
    logic [63:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return a;
      4, 5:       return (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
      6:          return {64{1'b1}};
      7:          return '0;
      default:    return a & b;
    endcase
  endfunction

  task automatic send_tick(input logic [63:0] spawn_row, output bit active);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_spawn_row <= spawn_row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    active = advance_frame(spawn_row);
  endtask

  // hold ticks until every row is out, then let the step finish
  task automatic drain_rows();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [7:0] value);
    logic [31:0] word;
    word    = {$urandom} & 32'hFFFF_FF00 | {24'd0, value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == fsge_pkg::REG_SPAWN) spawn_cfg_q = word[7:0];
    else                                wait_cfg_q  = word[7:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stall bursts, none once quiet
  always @(posedge clk) begin
    if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 10);
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: row with none expected: expected none, actual idx %0d bits %h",
                   $time, out_row_index, out_row_bits);
      end else begin
        row_head = expected_rows.pop_front();
        if (out_row_index !== row_head.row_index) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: row_index expected %0d actual %0d",
                     $time, row_head.row_index, out_row_index);
        end
        if (out_row_bits !== row_head.row_bits) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: row_bits (row %0d) expected %h actual %h",
                     $time, row_head.row_index, row_head.row_bits, out_row_bits);
        end
        if (out_last_row !== row_head.last_row) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: last_row (row %0d) expected %b actual %b",
                     $time, row_head.row_index, row_head.last_row, out_last_row);
        end
        if (out_clearing_phase !== row_head.clearing_phase) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: clearing_phase (row %0d) expected %b actual %b",
                     $time, row_head.row_index, row_head.clearing_phase,
                     out_clearing_phase);
        end
      end
    end
  end

  initial begin
    bit active;
    int frames;
    reset_grid_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_TABLE; i++) begin
      send_tick(directed_ticks[i].spawn_row, active);
      if (active && directed_ticks[i].top_known)
        expected_rows[expected_rows.size() - ROWS].row_bits = directed_ticks[i].top_row;
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_rows();
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      apb_write(ADDR_SPAWN, sand_phases[p].spawn_count);
      apb_write(ADDR_WAIT, sand_phases[p].wait_count);
      frames = 0;
      while (frames < sand_phases[p].frames) begin
        send_tick(random_spawn_row(), active);
        if (active) frames++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/fsge_pkg.sv
hdl/fsge_chunk.sv
hdl/falling_sand_grid_engine_core.sv
sim/tb_falling_sand_grid_engine_core.sv
